FILE: rtl/spectral_complex_mac_top_defines.svh
// Assertion macros shared by the spectral complex MAC checker.
// Included by scmac_checker.sv; depends on nothing else.
`ifndef SPECTRAL_COMPLEX_MAC_TOP_DEFINES_SVH
`define SPECTRAL_COMPLEX_MAC_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCMAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCMAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define SCMAC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/scmac_pkg.sv
// Package of the spectral complex MAC: fixed widths, depth and mode codes.
// No dependencies; used by the interfaces, the top level and the checker.
`timescale 1ns / 1ps

package scmac_pkg;

    localparam int BIN_W     = 12;
    localparam int BIN_COUNT = 4096;
    localparam int ACC_W     = 56;

    localparam logic MODE_RECON = 1'b0;
    localparam logic MODE_CORR  = 1'b1;

    typedef logic [BIN_W-1:0]        t_bin;
    typedef logic signed [ACC_W-1:0] t_acc;

endpackage

FILE: rtl/scmac_if.sv
// Request and response channel interfaces of the spectral complex MAC.
// Depends on scmac_pkg.
`timescale 1ns / 1ps

interface scmac_req_if import scmac_pkg::*; #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic                          mode;
    t_bin                          bin;
    logic                          restart;
    logic signed [SAMPLE_BITS-1:0] x_re;
    logic signed [SAMPLE_BITS-1:0] x_im;
    logic signed [SAMPLE_BITS-1:0] a_re;
    logic signed [SAMPLE_BITS-1:0] a_im;

    modport source (output valid, mode, bin, restart, x_re, x_im, a_re, a_im,
                    input ready);
    modport sink   (input valid, mode, bin, restart, x_re, x_im, a_re, a_im,
                    output ready);
endinterface

interface scmac_rsp_if import scmac_pkg::*;;
    logic valid;
    logic ready;
    t_bin out_bin;
    t_acc sum_re;
    t_acc sum_im;

    modport source (output valid, out_bin, sum_re, sum_im, input ready);
    modport sink   (input valid, out_bin, sum_re, sum_im, output ready);
endinterface

FILE: rtl/spectral_complex_mac_top.sv
// Spectral complex multiply-accumulate into a 4096-bin memory.
// Depends on scmac_pkg and the channel interfaces in scmac_if.sv.
//
// Each request names a bin and carries complex samples x and a. Mode
// reconstruction adds x*a to the bin, mode correlation adds conj(a)*x.
// With restart set the bin counts as zero before the addition. Every
// request yields one response with the bin and its updated saturated sum.
// An accepted request waits in the multiply stage, then enters the response
// register when that is free or being taken. One request is taken per cycle
// unless the receiver stalls; the bin memory is read when a request is
// accepted and written when it leaves the multiply stage, and a request
// that hits the bin written in that same cycle takes the new sum from a
// bypass register. Reset clears the valid and bypass flags only; the bin
// memory holds no defined value until each bin has been written, so a bin
// must first be used with restart set. When the receiver stalls, the
// response register holds; a waiting multiply-stage request drops ready.
`timescale 1ns / 1ps

module spectral_complex_mac_top import scmac_pkg::*; #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    scmac_req_if.sink    i_req,
    scmac_rsp_if.source  o_rsp
);

    localparam int PW   = 2 * SAMPLE_BITS;
    localparam int SUMW = ((PW > ACC_W) ? PW : ACC_W) + 2;

    t_acc r_mem_re [BIN_COUNT];
    t_acc r_mem_im [BIN_COUNT];
    t_acc r_rd_re;
    t_acc r_rd_im;
    t_acc r_wb_re;
    t_acc r_wb_im;

    logic                 r_s1_valid;
    logic                 r_s1_fwd;
    logic                 r_s1_mode;
    logic                 r_s1_restart;
    t_bin                 r_s1_bin;
    logic signed [PW-1:0] r_p_rr;
    logic signed [PW-1:0] r_p_ii;
    logic signed [PW-1:0] r_p_ri;
    logic signed [PW-1:0] r_p_ir;

    logic r_o_valid;
    t_bin r_o_bin;
    t_acc r_o_re;
    t_acc r_o_im;

    logic w_s1_adv;
    logic w_req_fire;

    t_acc                   w_old_re;
    t_acc                   w_old_im;
    logic signed [SUMW-1:0] w_rr;
    logic signed [SUMW-1:0] w_ii;
    logic signed [SUMW-1:0] w_ri;
    logic signed [SUMW-1:0] w_ir;
    logic signed [SUMW-1:0] w_tot_re;
    logic signed [SUMW-1:0] w_tot_im;
    t_acc                   n_sum_re;
    t_acc                   n_sum_im;

    function automatic t_acc f_sat(input logic signed [SUMW-1:0] v);
        logic [SUMW-ACC_W:0] top;
        t_acc                res;
        top = v[SUMW-1:ACC_W-1];
        if ((&top) || !(|top)) begin
            res = v[ACC_W-1:0];
        end else if (v[SUMW-1]) begin
            res = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(ACC_W-1){1'b1}}};
        end
        return res;
    endfunction

    assign w_s1_adv   = r_s1_valid && (!r_o_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || w_s1_adv;
    assign w_req_fire = i_req.valid && i_req.ready;

    always_comb begin
        if (r_s1_restart) begin
            w_old_re = '0;
            w_old_im = '0;
        end else if (r_s1_fwd) begin
            w_old_re = r_wb_re;
            w_old_im = r_wb_im;
        end else begin
            w_old_re = r_rd_re;
            w_old_im = r_rd_im;
        end
        w_rr = {{(SUMW-PW){r_p_rr[PW-1]}}, r_p_rr};
        w_ii = {{(SUMW-PW){r_p_ii[PW-1]}}, r_p_ii};
        w_ri = {{(SUMW-PW){r_p_ri[PW-1]}}, r_p_ri};
        w_ir = {{(SUMW-PW){r_p_ir[PW-1]}}, r_p_ir};
        if (r_s1_mode == MODE_CORR) begin
            w_ri = -w_ri;
        end else begin
            w_ii = -w_ii;
        end
        w_tot_re = {{(SUMW-ACC_W){w_old_re[ACC_W-1]}}, w_old_re} + w_rr + w_ii;
        w_tot_im = {{(SUMW-ACC_W){w_old_im[ACC_W-1]}}, w_old_im} + w_ri + w_ir;
        n_sum_re = f_sat(w_tot_re);
        n_sum_im = f_sat(w_tot_im);
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_mem_re[r_s1_bin] <= n_sum_re;
            r_mem_im[r_s1_bin] <= n_sum_im;
        end
        if (w_req_fire) begin
            r_rd_re <= r_mem_re[i_req.bin];
            r_rd_im <= r_mem_im[i_req.bin];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req_fire) begin
            r_s1_mode    <= i_req.mode;
            r_s1_restart <= i_req.restart;
            r_s1_bin     <= i_req.bin;
            r_p_rr       <= i_req.x_re * i_req.a_re;
            r_p_ii       <= i_req.x_im * i_req.a_im;
            r_p_ri       <= i_req.x_re * i_req.a_im;
            r_p_ir       <= i_req.x_im * i_req.a_re;
        end
        if (w_s1_adv) begin
            r_wb_re <= n_sum_re;
            r_wb_im <= n_sum_im;
            r_o_bin <= r_s1_bin;
            r_o_re  <= n_sum_re;
            r_o_im  <= n_sum_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_req_fire) begin
                r_s1_valid <= 1'b1;
                r_s1_fwd   <= w_s1_adv && (r_s1_bin == i_req.bin);
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid   = r_o_valid;
    assign o_rsp.out_bin = r_o_bin;
    assign o_rsp.sum_re  = r_o_re;
    assign o_rsp.sum_im  = r_o_im;

endmodule

FILE: rtl/scmac_checker.sv
// Port-level checker of the spectral complex MAC and its bind to the top level.
// Depends on scmac_pkg and spectral_complex_mac_top_defines.svh.
`timescale 1ns / 1ps
`include "spectral_complex_mac_top_defines.svh"

module scmac_checker import scmac_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_bin i_out_bin,
    input t_acc i_sum_re,
    input t_acc i_sum_im
);

    `SCMAC_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_out_bin) && $stable(i_sum_re) && $stable(i_sum_im), "stalled response changed")
    `SCMAC_ASSERT_NEXT_ALWAYS(a_rst_idle, i_clk, !i_rst_n, !i_rsp_valid, "response valid after reset")
    `SCMAC_ASSERT_NOW(a_ready_low, i_clk, i_rst_n, !i_req_ready, i_rsp_valid && !i_rsp_ready, "request stalled without a stalled response")
    `SCMAC_ASSERT_NEXT(a_backpress, i_clk, i_rst_n, i_req_valid && i_req_ready && i_rsp_valid && !i_rsp_ready, i_req_ready == i_rsp_ready, "request stage did not wait for the response")

endmodule

bind spectral_complex_mac_top scmac_checker u_scmac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_out_bin   (o_rsp.out_bin),
    .i_sum_re    (o_rsp.sum_re),
    .i_sum_im    (o_rsp.sum_im)
);
